[hw/rtl/cpp_pkg.sv]
// ----------------------------------------------------------------------------
// cpp_pkg: camera point projection package
// Shared widths, codes, payload types and latency constants.
// ----------------------------------------------------------------------------
package cpp_pkg;

    // Camera table geometry
    localparam int NUM_CAMERAS = 256;
    localparam int CAM_AW      = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;
    localparam int NUM_ROWS    = 3;
    localparam int NUM_COLS    = 4;
    localparam int NUM_COEF    = NUM_ROWS * NUM_COLS;

    // Field widths
    localparam int COEF_W  = 48;
    localparam int PT_W    = 32;
    localparam int FRAC_W  = 16;
    localparam int SIZE_W  = 16;
    localparam int IMG_W   = 32;
    localparam int STAT_W  = 2;

    // Datapath widths
    localparam int LO_W      = 24;                       // low coefficient slice
    localparam int PP_LO_W   = LO_W + 1 + PT_W;
    localparam int PP_HI_W   = COEF_W - LO_W + PT_W;
    localparam int PROD_W    = COEF_W + PT_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int MAG_W     = PROD_W;                   // |row sum| < 2^80
    localparam int MAG_HALF  = MAG_W / 2;
    localparam int DP_W      = MAG_HALF + SIZE_W;
    localparam int DEN_W     = MAG_W + SIZE_W;
    localparam int QFRAC     = 30;
    localparam int NUM_W     = MAG_W + QFRAC;
    localparam int QB        = IMG_W + 1;                // quotient bits kept
    localparam int CMP_W     = DEN_W + QB;

    // Latencies
    localparam int PRE_LAT = 7;                          // product to divisor
    localparam int DIV_LAT = QB + 2;
    localparam int BK_LAT  = PRE_LAT + DIV_LAT;

    // Queue between front and back (depth is a power of two)
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Commands
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROJECT = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;
    localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RST  = 16'd3648;
    localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RST = 16'd2736;

    // Saturation limits
    localparam logic [IMG_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [IMG_W-1:0] Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic                     cmd;
        logic [7:0]               cam_index;
        logic [3:0]               coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [PT_W-1:0]   point_x;
        logic signed [PT_W-1:0]   point_y;
        logic signed [PT_W-1:0]   point_z;
    } item_t;

    typedef struct packed {
        logic signed [IMG_W-1:0] image_x;
        logic signed [IMG_W-1:0] image_y;
        logic [STAT_W-1:0]       status;
    } result_t;

    // Project transaction with its camera matrix fetched
    typedef struct packed {
        logic [NUM_COEF-1:0][COEF_W-1:0] coef;
        logic signed [PT_W-1:0]          point_x;
        logic signed [PT_W-1:0]          point_y;
        logic signed [PT_W-1:0]          point_z;
    } proj_t;

endpackage

[hw/rtl/camera_point_projection_core.sv]
// ----------------------------------------------------------------------------
// camera_point_projection_core: pinhole projection through a 3x4 matrix
// Path: a project result passes through one table read, one queue slot and
// 42 back-end stages after its transaction is accepted.
// Throughput: one transaction per cycle while results are taken; the back end
// holds one quotient bit per stage in each of its two dividers.
// Reset: control state clears; the matrix table is undefined until written.
// ----------------------------------------------------------------------------
module camera_point_projection_core
    import cpp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result
);

    logic [SIZE_W-1:0]  image_width_reg;
    logic [SIZE_W-1:0]  image_height_reg;
    logic               push;
    proj_t              push_data;
    logic               pop;
    proj_t              head;
    logic               fifo_empty;
    logic [FIFO_CW-1:0] fifo_count;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:          image_width_reg  <= image_width_reg;
            endcase
        end
    end

    cpp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .fifo_count (fifo_count),
        .push       (push),
        .push_data  (push_data)
    );

    cpp_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_data),
        .pop   (pop),
        .dout  (head),
        .empty (fifo_empty),
        .count (fifo_count)
    );

    cpp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .fifo_empty   (fifo_empty),
        .head         (head),
        .pop          (pop),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

[hw/rtl/cpp_front.sv]
// ----------------------------------------------------------------------------
// cpp_front: command front end
// Accepts transactions, writes loads into the matrix banks and fetches the
// matrix for projects, handing them on to the queue.
// ----------------------------------------------------------------------------
module cpp_front
    import cpp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  item_t              item,
    input  logic [FIFO_CW-1:0] fifo_count,
    output logic               push,
    output proj_t              push_data
);

    logic                            pend_reg;
    logic signed [PT_W-1:0]          px_reg;
    logic signed [PT_W-1:0]          py_reg;
    logic signed [PT_W-1:0]          pz_reg;
    logic [NUM_COEF-1:0][COEF_W-1:0] rd_data;
    logic                            accept;
    logic                            is_load;
    logic                            is_proj;
    logic [CAM_AW-1:0]               addr;

    // Room for this transaction and the one still in flight
    assign item_ready = (fifo_count + FIFO_CW'(pend_reg)) < FIFO_CW'(FIFO_DEPTH);
    assign accept     = item_valid && item_ready;
    assign is_load    = (item.cmd == CMD_LOAD);
    assign is_proj    = (item.cmd == CMD_PROJECT);
    assign addr       = CAM_AW'(item.cam_index % NUM_CAMERAS);

    // One bank per coefficient position
    for (genvar b = 0; b < NUM_COEF; b++) begin : g_bank
        logic [COEF_W-1:0] mem [NUM_CAMERAS];
        logic [COEF_W-1:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (accept && is_load && (item.coef_index == 4'(b)))
            begin
                mem[addr] <= item.coef_value;
            end
            if (accept && is_proj)
            begin
                rd_reg <= mem[addr];
            end
        end

        assign rd_data[b] = rd_reg;
    end

    // Point travels alongside the fetched matrix
    always_ff @(posedge clk)
    begin
        if (accept && is_proj)
        begin
            px_reg <= item.point_x;
            py_reg <= item.point_y;
            pz_reg <= item.point_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= accept && is_proj;
        end
    end

    assign push      = pend_reg;
    assign push_data = '{coef: rd_data, point_x: px_reg, point_y: py_reg, point_z: pz_reg};

endmodule

[hw/rtl/cpp_fifo.sv]
// ----------------------------------------------------------------------------
// cpp_fifo: project queue
// Short first-word-fall-through queue between the front and the back end.
// ----------------------------------------------------------------------------
module cpp_fifo
    import cpp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  proj_t              din,
    input  logic               pop,
    output proj_t              dout,
    output logic               empty,
    output logic [FIFO_CW-1:0] count
);

    proj_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg;
    logic [FIFO_AW-1:0]  rd_ptr_reg;
    logic [FIFO_CW-1:0]  count_reg;
    logic [FIFO_CW-1:0]  count_next;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + FIFO_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FIFO_CW'(1);
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

[hw/rtl/cpp_div.sv]
// ----------------------------------------------------------------------------
// cpp_div: pipelined Q2.30 divider
// Restoring division, one quotient bit per stage, with overflow detection
// and signed saturation in the last stage.
// ----------------------------------------------------------------------------
module cpp_div
    import cpp_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic             neg,
    output logic [IMG_W-1:0] quo,
    output logic             sat
);

    logic [NUM_W-1:0] rem_reg  [QB];
    logic [DEN_W-1:0] den_reg  [QB];
    logic [QB-1:0]    q_reg    [QB+1];
    logic             ovf_reg  [QB+1];
    logic             neg_reg  [QB+1];
    logic [NUM_W-1:0] rem_next [QB];
    logic [QB-1:0]    q_next   [QB];
    logic [IMG_W-1:0] quo_reg;
    logic             sat_reg;
    logic [QB-1:0]    qf;
    logic             sat_f;

    // One trial subtraction per stage
    always_comb
    begin
        logic [CMP_W-1:0] dsh;
        logic             take;
        for (int j = 0; j < QB; j++)
        begin
            dsh  = CMP_W'(den_reg[j]) << (QB - 1 - j);
            take = CMP_W'(rem_reg[j]) >= dsh;
            rem_next[j] = take ? NUM_W'(CMP_W'(rem_reg[j]) - dsh) : rem_reg[j];
            q_next[j]   = take ? (q_reg[j] | (QB'(1) << (QB - 1 - j))) : q_reg[j];
        end
    end

    // Stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= CMP_W'(num) >= (CMP_W'(den) << QB);
            neg_reg[0] <= neg;
            for (int j = 0; j < QB; j++)
            begin
                q_reg[j+1]   <= q_next[j];
                ovf_reg[j+1] <= ovf_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end
            for (int j = 0; j < QB - 1; j++)
            begin
                rem_reg[j+1] <= rem_next[j];
                den_reg[j+1] <= den_reg[j];
            end
            sat_reg <= sat_f;
            if (sat_f)
            begin
                quo_reg <= neg_reg[QB] ? Q_MIN : Q_MAX;
            end
            else
            begin
                quo_reg <= neg_reg[QB] ? (IMG_W'(0) - qf[IMG_W-1:0]) : qf[IMG_W-1:0];
            end
        end
    end

    // Range check: positive up to 2^31-1, negative down to -2^31
    assign qf    = q_reg[QB];
    assign sat_f = ovf_reg[QB] || qf[QB-1] ||
                   (neg_reg[QB] ? (qf[IMG_W-1] && (qf[IMG_W-2:0] != '0)) : qf[IMG_W-1]);

    assign quo = quo_reg;
    assign sat = sat_reg;

endmodule

[hw/rtl/cpp_back.sv]
// ----------------------------------------------------------------------------
// cpp_back: projection back end
// Row dot products, depth scaling and the two divisions, as one pipeline
// that advances whenever the result register is free.
// ----------------------------------------------------------------------------
module cpp_back
    import cpp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fifo_empty,
    input  proj_t             head,
    output logic              pop,
    input  logic [SIZE_W-1:0] image_width,
    input  logic [SIZE_W-1:0] image_height,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result
);

    localparam int ZS = 4;                        // stage where depth is known

    logic                       vld_reg  [BK_LAT];
    logic                       zero_reg [ZS:BK_LAT-1];
    logic                       adv;

    logic signed [PP_LO_W-1:0]  pl_reg   [NUM_ROWS][NUM_ROWS];
    logic signed [PP_HI_W-1:0]  ph_reg   [NUM_ROWS][NUM_ROWS];
    logic signed [COEF_W-1:0]   off1_reg [NUM_ROWS];
    logic signed [PROD_W-1:0]   prod_reg [NUM_ROWS][NUM_ROWS];
    logic signed [COEF_W-1:0]   off2_reg [NUM_ROWS];
    logic signed [SUM_W-1:0]    a_reg    [NUM_ROWS];
    logic signed [SUM_W-1:0]    b_reg    [NUM_ROWS];
    logic signed [SUM_W-1:0]    s_reg    [NUM_ROWS];
    logic [MAG_W-1:0]           mag5_reg [NUM_ROWS];
    logic                       sgn5_reg [NUM_ROWS];
    logic [DP_W-1:0]            dl_reg   [2];
    logic [DP_W-1:0]            dh_reg   [2];
    logic [MAG_W-1:0]           nm6_reg  [2];
    logic                       neg6_reg [2];
    logic [DEN_W-1:0]           den7_reg [2];
    logic [MAG_W-1:0]           nm7_reg  [2];
    logic                       neg7_reg [2];

    logic signed [PT_W-1:0]     pt      [NUM_ROWS];
    logic [SIZE_W-1:0]          size_eff[2];
    logic [IMG_W-1:0]           quo     [2];
    logic                       sat     [2];
    logic                       zero_out;

    // Whole pipeline moves when the result register is empty or taken
    assign adv = !vld_reg[BK_LAT-1] || result_ready;
    assign pop = adv && !fifo_empty;

    assign pt[0] = head.point_x;
    assign pt[1] = head.point_y;
    assign pt[2] = head.point_z;

    // Zero size acts as one
    assign size_eff[0] = (image_width  == '0) ? SIZE_W'(1) : image_width;
    assign size_eff[1] = (image_height == '0) ? SIZE_W'(1) : image_height;

    // Valid and zero-depth lines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < BK_LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= !fifo_empty;
            for (int k = 1; k < BK_LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zero_reg[ZS] <= (s_reg[2] == '0);
            for (int k = ZS + 1; k < BK_LAT; k++)
            begin
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    end

    // Arithmetic stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // partial products of each coefficient and point coordinate
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                for (int k = 0; k < NUM_ROWS; k++)
                begin
                    pl_reg[r][k] <= $signed({1'b0, head.coef[r*NUM_COLS+k][LO_W-1:0]}) * pt[k];
                    ph_reg[r][k] <= $signed(head.coef[r*NUM_COLS+k][COEF_W-1:LO_W]) * pt[k];
                end
                off1_reg[r] <= $signed(head.coef[r*NUM_COLS+NUM_ROWS]);
            end

            // full products
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                for (int k = 0; k < NUM_ROWS; k++)
                begin
                    prod_reg[r][k] <= (PROD_W'(ph_reg[r][k]) <<< LO_W) + PROD_W'(pl_reg[r][k]);
                end
                off2_reg[r] <= off1_reg[r];
            end

            // pairwise sums, offset aligned to 32 fraction bits
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                a_reg[r] <= SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1]);
                b_reg[r] <= SUM_W'(prod_reg[r][2]) + (SUM_W'(off2_reg[r]) <<< FRAC_W);
            end

            for (int r = 0; r < NUM_ROWS; r++)
            begin
                s_reg[r] <= a_reg[r] + b_reg[r];
            end

            // sign and magnitude
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                sgn5_reg[r] <= s_reg[r][SUM_W-1];
                mag5_reg[r] <= MAG_W'(s_reg[r][SUM_W-1] ? -s_reg[r] : s_reg[r]);
            end

            // depth times image size, in two halves
            for (int i = 0; i < 2; i++)
            begin
                dl_reg[i]   <= DP_W'(mag5_reg[2][MAG_HALF-1:0]) * DP_W'(size_eff[i]);
                dh_reg[i]   <= DP_W'(mag5_reg[2][MAG_W-1:MAG_HALF]) * DP_W'(size_eff[i]);
                nm6_reg[i]  <= mag5_reg[i];
                neg6_reg[i] <= sgn5_reg[i] ^ sgn5_reg[2];
            end

            for (int i = 0; i < 2; i++)
            begin
                den7_reg[i] <= (DEN_W'(dh_reg[i]) << MAG_HALF) + DEN_W'(dl_reg[i]);
                nm7_reg[i]  <= nm6_reg[i];
                neg7_reg[i] <= neg6_reg[i];
            end
        end
    end

    // x and y dividers
    for (genvar i = 0; i < 2; i++) begin : g_div
        cpp_div u_div (
            .clk (clk),
            .en  (adv),
            .num ({nm7_reg[i], QFRAC'(0)}),
            .den (den7_reg[i]),
            .neg (neg7_reg[i]),
            .quo (quo[i]),
            .sat (sat[i])
        );
    end

    // Result register is the last divider stage
    assign zero_out     = zero_reg[BK_LAT-1];
    assign result_valid = vld_reg[BK_LAT-1];

    always_comb
    begin
        result.image_x = zero_out ? '0 : $signed(quo[0]);
        result.image_y = zero_out ? '0 : $signed(quo[1]);
        priority if (zero_out)
        begin
            result.status = ST_ZERO;
        end
        else if (sat[0] || sat[1])
        begin
            result.status = ST_SAT;
        end
        else
        begin
            result.status = ST_OK;
        end
    end

endmodule

[tb/camera_point_projection_core_tb.sv]
// ----------------------------------------------------------------------------
// camera_point_projection_core_tb: self-checking bench for the projection core
// Loads camera matrices, streams project transactions with random gaps and
// stalls, and checks every result against an exact fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module camera_point_projection_core_tb;
    import cpp_pkg::*;

    // Expected-result store with its own copy of the camera table and sizes
    class projection_scoreboard;
        logic signed [COEF_W-1:0] cam_coef [NUM_CAMERAS][NUM_COEF];
        logic [SIZE_W-1:0] width_reg;
        logic [SIZE_W-1:0] height_reg;
        result_t pending [$];
        int errors;
        int n_ok;
        int n_zero;
        int n_sat;

        function new();
            width_reg  = IMAGE_WIDTH_RST;
            height_reg = IMAGE_HEIGHT_RST;
            errors = 0;
            n_ok = 0;
            n_zero = 0;
            n_sat = 0;
        endfunction

        function void set_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
            if (idx == CFG_IMAGE_WIDTH)
                width_reg = val;
            else
                height_reg = val;
        endfunction

        // exact row sum, 32 fraction bits
        function logic signed [127:0] row_dot(int cam, int r, item_t it);
            logic signed [127:0] acc;
            logic signed [127:0] c;
            logic signed [127:0] p [3];
            p[0] = 128'(it.point_x);
            p[1] = 128'(it.point_y);
            p[2] = 128'(it.point_z);
            acc = 0;
            for (int k = 0; k < 3; k++)
            begin
                c = 128'(cam_coef[cam][r*NUM_COLS+k]);
                acc = acc + c * p[k];
            end
            c = 128'(cam_coef[cam][r*NUM_COLS+3]);
            return acc + (c <<< FRAC_W);
        endfunction

        // Q2.30 quotient truncated toward zero, saturated
        function logic [IMG_W-1:0] q30(logic signed [127:0] s, logic [127:0] den,
                                       bit zneg, inout bit sat);
            logic [127:0] mag;
            logic [127:0] q;
            bit neg;
            neg = (s < 0) != zneg;
            mag = (s < 0) ? -s : s;
            q = (mag << QFRAC) / den;
            if (!neg)
            begin
                if (q > 128'h7FFF_FFFF)
                begin
                    sat = 1;
                    return Q_MAX;
                end
                return q[IMG_W-1:0];
            end
            if (q > 128'h8000_0000)
            begin
                sat = 1;
                return Q_MIN;
            end
            return -q[IMG_W-1:0];
        endfunction

        function void note_item(item_t it);
            int cam;
            logic signed [127:0] sx, sy, sz;
            logic [127:0] az, w, h;
            bit sat;
            result_t r;
            cam = int'(it.cam_index) % NUM_CAMERAS;
            if (it.cmd == CMD_LOAD)
            begin
                if (it.coef_index < NUM_COEF)
                    cam_coef[cam][it.coef_index] = it.coef_value;
                return;
            end
            sx = row_dot(cam, 0, it);
            sy = row_dot(cam, 1, it);
            sz = row_dot(cam, 2, it);
            if (sz == 0)
            begin
                r.image_x = '0;
                r.image_y = '0;
                r.status  = ST_ZERO;
                n_zero++;
            end
            else
            begin
                sat = 0;
                az = (sz < 0) ? -sz : sz;
                w = (width_reg == 0) ? 128'd1 : 128'(width_reg);
                h = (height_reg == 0) ? 128'd1 : 128'(height_reg);
                r.image_x = q30(sx, az * w, sz < 0, sat);
                r.image_y = q30(sy, az * h, sz < 0, sat);
                r.status  = sat ? ST_SAT : ST_OK;
                if (sat)
                    n_sat++;
                else
                    n_ok++;
            end
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result x=%h y=%h status=%0d",
                         $time, got.image_x, got.image_y, got.status);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.image_x !== exp_r.image_x)
            begin
                $display("%0t: image_x expected %h actual %h", $time, exp_r.image_x, got.image_x);
                errors++;
            end
            if (got.image_y !== exp_r.image_y)
            begin
                $display("%0t: image_y expected %h actual %h", $time, exp_r.image_y, got.image_y);
                errors++;
            end
            if (got.status !== exp_r.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]    cfg_data = '0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    item_t                item = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_t              result;

    projection_scoreboard sb = new();
    logic [NUM_COEF-1:0] loaded [NUM_CAMERAS];
    int  ready_cams [$];
    bit  no_idle = 0;
    int  stall_left = 0;
    int  quiet_cycles = 0;
    int  n_items = 0;

    camera_point_projection_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(10, 50);
    endfunction

    // Result side: random back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // Result monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
        if ((item_valid && item_ready) || (result_valid && result_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, sb.pending.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Drive one transaction, idling first; valid is only lowered when a gap comes before it
    task automatic send(item_t it);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            item_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        sb.note_item(it);
        n_items++;
        if (it.cmd == CMD_LOAD && it.coef_index < NUM_COEF)
        begin
            loaded[it.cam_index][it.coef_index] = 1'b1;
            if (loaded[it.cam_index] == '1 && !(it.cam_index inside {ready_cams}))
                ready_cams.insert(ready_cams.size(), int'(it.cam_index));
        end
    endtask

    function automatic logic signed [COEF_W-1:0] rand_coef();
        logic [63:0] v;
        int k;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0)
            return v[COEF_W-1:0];
        k = $urandom_range(8, 40);
        v = v & ((64'd1 << k) - 1);
        return $urandom_range(0, 1) ? -$signed(v[COEF_W-1:0]) : v[COEF_W-1:0];
    endfunction

    function automatic logic signed [PT_W-1:0] rand_point();
        logic [31:0] v;
        int k;
        v = $urandom;
        if ($urandom_range(0, 3) == 0)
            return v;
        k = $urandom_range(4, 24);
        v = v & ((32'd1 << k) - 1);
        return $urandom_range(0, 1) ? -$signed(v) : v;
    endfunction

    task automatic load_coef(int cam, int idx, logic signed [COEF_W-1:0] val);
        item_t it;
        it.cmd        = CMD_LOAD;
        it.cam_index  = 8'(cam);
        it.coef_index = 4'(idx);
        it.coef_value = val;
        it.point_x    = $urandom;
        it.point_y    = $urandom;
        it.point_z    = $urandom;
        send(it);
    endtask

    task automatic project(int cam, logic signed [PT_W-1:0] x, logic signed [PT_W-1:0] y,
                           logic signed [PT_W-1:0] z);
        item_t it;
        it.cmd        = CMD_PROJECT;
        it.cam_index  = 8'(cam);
        it.coef_index = 4'($urandom);
        it.coef_value = COEF_W'({$urandom, $urandom});
        it.point_x    = x;
        it.point_y    = y;
        it.point_z    = z;
        send(it);
    endtask

    // Wait until every expected result is back, then let the pipeline settle
    task automatic drain();
        item_valid <= 1'b0;
        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_sizes(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
        cfg_we <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        sb.set_size(CFG_IMAGE_WIDTH, w);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        sb.set_size(CFG_IMAGE_HEIGHT, h);
        cfg_we <= 1'b0;
    endtask

    // Well-formed traffic: at times fill a camera, then project points through loaded cameras
    task automatic random_phase(int count);
        int start;
        int cam;
        int n;
        start = n_items;
        while (n_items - start < count)
        begin
            if (ready_cams.size() < 3 || $urandom_range(0, 5) == 0)
            begin
                cam = $urandom_range(0, NUM_CAMERAS - 1);
                for (int k = 0; k < NUM_COEF; k++)
                    load_coef(cam, k, rand_coef());
                if ($urandom_range(0, 2) == 0)
                    load_coef(cam, $urandom_range(NUM_COEF, 15), rand_coef());
            end
            n = $urandom_range(1, 25);
            if ($urandom_range(0, 7) == 0)
                no_idle = ~no_idle;
            for (int i = 0; i < n; i++)
                project(ready_cams[$urandom_range(0, ready_cams.size() - 1)],
                        rand_point(), rand_point(), rand_point());
        end
    endtask

    initial
    begin
        logic signed [COEF_W-1:0] one;
        one = 48'sd1 <<< FRAC_W;
        for (int c = 0; c < NUM_CAMERAS; c++)
            loaded[c] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: simple pinhole camera 0, zero camera 255, extreme camera 7
        for (int k = 0; k < NUM_COEF; k++)
            load_coef(0, k, (k == 0 || k == 5) ? 48'sd1000 * one :
                            (k == 2) ? 48'sd1824 * one : (k == 6) ? 48'sd1368 * one :
                            (k == 10) ? one : '0);
        load_coef(0, 14, 48'h7FFF_FFFF_FFFF);
        for (int k = 0; k < NUM_COEF; k++)
            load_coef(255, k, '0);
        for (int k = 0; k < NUM_COEF; k++)
            load_coef(7, k, (k % 2) ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF);
        project(0, 32'sd65536, -32'sd65536, 32'sd327680);
        project(0, 32'sd1, 32'sd1, 32'sd0);
        project(255, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        project(7, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        project(7, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
        project(0, 32'h8000_0000, 32'h8000_0000, -32'sd1);
        drain();

        // Size settings through the run, extremes included
        write_sizes(16'd1, 16'd1);
        random_phase(340);
        drain();
        write_sizes(16'd0, 16'd0);
        random_phase(340);
        // sender holds off until every result is back
        item_valid <= 1'b0;
        while (sb.pending.size() > 0)
            @(posedge clk);
        random_phase(100);
        drain();
        write_sizes(16'hFFFF, 16'hFFFF);
        random_phase(300);
        drain();
        write_sizes(SIZE_W'($urandom), SIZE_W'($urandom));
        random_phase(300);
        drain();
        write_sizes(IMAGE_WIDTH_RST, IMAGE_HEIGHT_RST);
        random_phase(300);
        drain();

        $display("Run covered %0d transactions over six size settings: %0d ok, %0d zero depth,",
                 n_items, sb.n_ok, sb.n_zero);
        $display("%0d saturated results, %0d cameras loaded, %0d mismatches",
                 sb.n_sat, ready_cams.size(), sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
